### rtl/core/slfc_pkg.sv
// -----------------------------------------------------------------------------
// slfc_pkg
// Shared constants and types for the sync-word, length-prefixed frame checker.
// -----------------------------------------------------------------------------
package slfc_pkg;

   localparam logic [7:0]  SYNC_HEAD     = 8'h5A;
   localparam logic [7:0]  SYNC_TAIL     = 8'hA5;
   localparam logic [15:0] MIN_FRAME     = 16'd8;
   localparam logic [15:0] PAYLOAD_START = 16'd6;

   // Frame offsets decoded before the payload starts.
   localparam logic [15:0] OFS_HEAD0   = 16'd0;
   localparam logic [15:0] OFS_HEAD1   = 16'd1;
   localparam logic [15:0] OFS_TYPE    = 16'd3;
   localparam logic [15:0] OFS_LEN_LO  = 16'd4;
   localparam logic [15:0] OFS_LEN_HI  = 16'd5;

   typedef enum logic [0:0] {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_TOO_SHORT = 3'd1,
      STATUS_LEN_ERR   = 3'd2,
      STATUS_BAD_HEAD  = 3'd3,
      STATUS_BAD_TAIL  = 3'd4
   } status_type;

   // One result item as it travels from the parser to the output register.
   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic [7:0]  frame_type;
      logic [15:0] payload_length;
      status_type  frame_status;
      logic        last;
   } result_type;

endpackage

### rtl/core/slfc_if.sv
// -----------------------------------------------------------------------------
// slfc_if
// Valid/ready channel interfaces for frame bytes in and results out.
// -----------------------------------------------------------------------------
interface slfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface slfc_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  payload_byte;
   logic [15:0] payload_index;
   logic [7:0]  frame_type;
   logic [15:0] payload_length;
   logic [2:0]  frame_status;
   logic        last;

   modport source (output valid, output result_kind, output payload_byte,
                   output payload_index, output frame_type, output payload_length,
                   output frame_status, output last, input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input payload_index, input frame_type, input payload_length,
                   input frame_status, input last, output ready);
endinterface

### rtl/core/slfc_parser.sv
// -----------------------------------------------------------------------------
// slfc_parser
// Frame state registers and the single-pass decode of one received byte.
// -----------------------------------------------------------------------------
module slfc_parser
   import slfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  logic       frame_end,
   output logic       res_valid,
   output result_type res_item
);

   logic [15:0] byte_count_ff, byte_count_in;
   logic        reached_ff, reached_in;
   logic        head_good_ff, head_good_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  len_low_ff, len_low_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  prev_ff, prev_in;

   logic [15:0] count_next;
   logic        decoding;
   logic        early;
   logic        head_upd;
   logic [7:0]  type_upd;
   logic [7:0]  len_low_upd;
   logic [15:0] length_upd;
   logic [15:0] left_upd;
   logic        reached_upd;
   logic        emit;
   status_type  status;

   always_comb begin
      count_next  = byte_count_ff + 16'd1;
      decoding    = !reached_ff;
      early       = decoding && (byte_count_ff < PAYLOAD_START);

      head_upd    = head_good_ff;
      if (decoding && (byte_count_ff == OFS_HEAD0 || byte_count_ff == OFS_HEAD1)
          && rx_byte != SYNC_HEAD) begin
         head_upd = 1'b0;
      end
      type_upd    = (decoding && byte_count_ff == OFS_TYPE) ? rx_byte : type_ff;
      len_low_upd = (decoding && byte_count_ff == OFS_LEN_LO) ? rx_byte : len_low_ff;
      if (decoding && byte_count_ff == OFS_LEN_HI) begin
         length_upd = {rx_byte, len_low_ff};
         left_upd   = {rx_byte, len_low_ff};
      end else begin
         length_upd = length_ff;
         left_upd   = left_ff;
      end

      emit        = !early && (left_upd != 16'd0);
      reached_upd = reached_ff || (count_next >= MIN_FRAME);

      // The first failing check sets the status.
      if (!reached_upd) begin
         status = STATUS_TOO_SHORT;
      end else if (length_upd != (count_next - MIN_FRAME)) begin
         status = STATUS_LEN_ERR;
      end else if (!head_upd) begin
         status = STATUS_BAD_HEAD;
      end else if (prev_ff != SYNC_TAIL || rx_byte != SYNC_TAIL) begin
         status = STATUS_BAD_TAIL;
      end else begin
         status = STATUS_OK;
      end

      res_item.frame_type     = type_upd;
      res_item.payload_length = length_upd;
      if (frame_end) begin
         res_valid              = 1'b1;
         res_item.result_kind   = KIND_STATUS;
         res_item.payload_byte  = 8'd0;
         res_item.payload_index = 16'd0;
         res_item.frame_status  = status;
         res_item.last          = 1'b1;
      end else begin
         res_valid              = emit;
         res_item.result_kind   = KIND_PAYLOAD;
         res_item.payload_byte  = rx_byte;
         res_item.payload_index = length_upd - left_upd;
         res_item.frame_status  = STATUS_OK;
         res_item.last          = 1'b0;
      end

      // Hold by default; a closing byte returns everything to reset values.
      byte_count_in = byte_count_ff;
      reached_in    = reached_ff;
      head_good_in  = head_good_ff;
      type_in       = type_ff;
      len_low_in    = len_low_ff;
      length_in     = length_ff;
      left_in       = left_ff;
      prev_in       = prev_ff;
      if (accept) begin
         if (frame_end) begin
            byte_count_in = 16'd0;
            reached_in    = 1'b0;
            head_good_in  = 1'b1;
            type_in       = 8'd0;
            len_low_in    = 8'd0;
            length_in     = 16'd0;
            left_in       = 16'd0;
            prev_in       = 8'd0;
         end else begin
            byte_count_in = count_next;
            reached_in    = reached_upd;
            head_good_in  = head_upd;
            type_in       = type_upd;
            len_low_in    = len_low_upd;
            length_in     = length_upd;
            left_in       = emit ? (left_upd - 16'd1) : left_upd;
            prev_in       = rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 16'd0;
         reached_ff    <= 1'b0;
         head_good_ff  <= 1'b1;
         type_ff       <= 8'd0;
         len_low_ff    <= 8'd0;
         length_ff     <= 16'd0;
         left_ff       <= 16'd0;
         prev_ff       <= 8'd0;
      end else begin
         byte_count_ff <= byte_count_in;
         reached_ff    <= reached_in;
         head_good_ff  <= head_good_in;
         type_ff       <= type_in;
         len_low_ff    <= len_low_in;
         length_ff     <= length_in;
         left_ff       <= left_in;
         prev_ff       <= prev_in;
      end
   end

endmodule

### rtl/core/slfc_out_reg.sv
// -----------------------------------------------------------------------------
// slfc_out_reg
// Result register that drives the response channel and grants new requests.
// -----------------------------------------------------------------------------
module slfc_out_reg
   import slfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic       res_valid,
   input  result_type res_item,
   output logic       can_take,
   slfc_rsp_if.source rsp
);

   logic       valid_ff, valid_in;
   result_type item_ff, item_in;
   logic       load_res;

   always_comb begin
      can_take = !valid_ff || rsp.ready;
      load_res = load && res_valid;
      if (load_res) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
      item_in = load_res ? res_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp.valid          = valid_ff;
   assign rsp.result_kind    = item_ff.result_kind;
   assign rsp.payload_byte   = item_ff.payload_byte;
   assign rsp.payload_index  = item_ff.payload_index;
   assign rsp.frame_type     = item_ff.frame_type;
   assign rsp.payload_length = item_ff.payload_length;
   assign rsp.frame_status   = item_ff.frame_status;
   assign rsp.last           = item_ff.last;

endmodule

### rtl/core/sync_length_frame_checker.sv
// A result appears on the response channel in the cycle after its request is accepted.
// Throughput: one request per cycle, limited only by the single result register.
// A request is taken whenever the result register is empty or is being read.
// Reset is synchronous and active high; it clears the frame state and empties
// the result register, so the next byte is taken as offset zero of a new frame.
// -----------------------------------------------------------------------------
// sync_length_frame_checker
// Checks sync-word, length-prefixed frames byte by byte, passing on the payload
// and closing each frame with a status result.
// -----------------------------------------------------------------------------
module sync_length_frame_checker
   import slfc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   slfc_req_if.sink   req_chan,
   slfc_rsp_if.source rsp_chan
);

   // A request is accepted when the result register can take whatever this
   // byte produces; bytes that produce nothing still move the frame state on.
   logic       accept;
   logic       can_take;
   logic       res_valid;
   result_type res_item;

   assign req_chan.ready = can_take;
   assign accept         = req_chan.valid && can_take;

   // Frame state and the whole decode of one byte live in the parser. It
   // tracks the offset, the head check, the type and length fields and the
   // number of payload bytes still due, and works out the status when the
   // marked last byte arrives.
   slfc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_chan.rx_byte),
      .frame_end (req_chan.frame_end),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   // The output register holds one result until the consumer takes it, and
   // lets a new request in during the same cycle that the old result leaves.
   slfc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .res_valid (res_valid),
      .res_item  (res_item),
      .can_take  (can_take),
      .rsp       (rsp_chan)
   );

endmodule

### bench/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sync-word, length-prefixed frame checker. Frames
// are sent one byte per request. A predictor in the bench works out every
// payload and status result, and each result is checked field by field as it
// leaves the block. Both channels idle at random, and one long receiver
// hold-off makes the block stall its input.
// -----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import slfc_pkg::*;

   // The limit leaves a wide margin above the length of the run.
   localparam int LIMIT_CYCLES  = 600000;
   localparam int RANDOM_ITEMS  = 1100;
   localparam int DRAIN_CYCLES  = 4;
   localparam int HOLD_OFF_LONG = 200;
   localparam int IDLE_PERCENT  = 7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slfc_req_if req_chan ();
   slfc_rsp_if rsp_chan ();

   sync_length_frame_checker DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bench-side copy of the frame state, at the widths the block uses.
   logic [15:0] frame_pos;
   logic        past_eight;
   logic        head_ok;
   logic [7:0]  held_type;
   logic [7:0]  held_len_lo;
   logic [15:0] held_len;
   logic [15:0] payload_to_go;
   logic [7:0]  prev_byte;

   // Results still owed by the block, oldest first.
   result_type  due_results[$];

   // The frame currently being assembled for sending.
   logic [7:0]  frame_bytes[$];

   int          error_count = 0;
   int          cycle_count = 0;
   int          items_sent = 0;
   bit          idling_on = 1'b1;
   int          hold_off_request = 0;
   int          hold_off_left = 0;

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   task automatic clear_frame_state();
      frame_pos     = '0;
      past_eight    = 1'b0;
      head_ok       = 1'b1;
      held_type     = '0;
      held_len_lo   = '0;
      held_len      = '0;
      payload_to_go = '0;
      prev_byte     = '0;
   endtask

   // Works out what one accepted request produces and queues it.
   task automatic decode_byte(input logic [7:0] rx, input logic fin);
      logic [15:0] pos;
      logic [15:0] next_count;
      logic        early;
      logic        emit;
      logic [15:0] index;
      result_type  outcome;
      status_type  verdict;

      pos        = frame_pos;
      next_count = frame_pos + 16'd1;
      early      = !past_eight && (pos < PAYLOAD_START);
      emit       = 1'b0;
      index      = '0;

      // The header offsets are decoded only on the first pass through them;
      // once eight bytes have been seen, a wrapped count does not re-decode.
      if (!past_eight) begin
         if (pos == OFS_HEAD0 || pos == OFS_HEAD1) begin
            if (rx != SYNC_HEAD) head_ok = 1'b0;
         end else if (pos == OFS_TYPE) begin
            held_type = rx;
         end else if (pos == OFS_LEN_LO) begin
            held_len_lo = rx;
         end else if (pos == OFS_LEN_HI) begin
            held_len      = {rx, held_len_lo};
            payload_to_go = {rx, held_len_lo};
         end
      end

      if (!early && payload_to_go != 16'd0) begin
         emit          = 1'b1;
         index         = held_len - payload_to_go;
         payload_to_go = payload_to_go - 16'd1;
      end

      if (!past_eight && next_count >= MIN_FRAME) past_eight = 1'b1;

      outcome = '0;
      if (fin) begin
         // The marked byte always closes the frame, even inside the payload.
         if (!past_eight) begin
            verdict = STATUS_TOO_SHORT;
         end else if (held_len != next_count - MIN_FRAME) begin
            verdict = STATUS_LEN_ERR;
         end else if (!head_ok) begin
            verdict = STATUS_BAD_HEAD;
         end else if (prev_byte != SYNC_TAIL || rx != SYNC_TAIL) begin
            verdict = STATUS_BAD_TAIL;
         end else begin
            verdict = STATUS_OK;
         end
         outcome.result_kind    = KIND_STATUS;
         outcome.frame_type     = held_type;
         outcome.payload_length = held_len;
         outcome.frame_status   = verdict;
         outcome.last           = 1'b1;
         due_results.insert(due_results.size(), outcome);
         clear_frame_state();
      end else begin
         frame_pos = next_count;
         prev_byte = rx;
         if (emit) begin
            outcome.result_kind    = KIND_PAYLOAD;
            outcome.payload_byte   = rx;
            outcome.payload_index  = index;
            outcome.frame_type     = held_type;
            outcome.payload_length = held_len;
            due_results.insert(due_results.size(), outcome);
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
               want);
      error_count++;
   endtask

   task automatic check_result();
      result_type want;

      if (due_results.size() == 0) begin
         report_mismatch("result with nothing expected", 16'(rsp_chan.result_kind),
                         16'd0);
         return;
      end
      want = due_results.pop_front();
      if (rsp_chan.result_kind !== want.result_kind)
         report_mismatch("result_kind", 16'(rsp_chan.result_kind),
                         16'(want.result_kind));
      if (rsp_chan.payload_byte !== want.payload_byte)
         report_mismatch("payload_byte", 16'(rsp_chan.payload_byte),
                         16'(want.payload_byte));
      if (rsp_chan.payload_index !== want.payload_index)
         report_mismatch("payload_index", rsp_chan.payload_index, want.payload_index);
      if (rsp_chan.frame_type !== want.frame_type)
         report_mismatch("frame_type", 16'(rsp_chan.frame_type), 16'(want.frame_type));
      if (rsp_chan.payload_length !== want.payload_length)
         report_mismatch("payload_length", rsp_chan.payload_length, want.payload_length);
      if (rsp_chan.frame_status !== want.frame_status)
         report_mismatch("frame_status", 16'(rsp_chan.frame_status),
                         16'(want.frame_status));
      if (rsp_chan.last !== want.last)
         report_mismatch("last", 16'(rsp_chan.last), 16'(want.last));
   endtask

   // Both handshakes are sampled at the rising edge, before any of the
   // nonblocking updates of that edge land, so the order of processes does
   // not matter. A result accepted at an edge always belongs to an earlier
   // request, so it is checked before the new request is predicted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) check_result();
         if (req_chan.valid && req_chan.ready)
            decode_byte(req_chan.rx_byte, req_chan.frame_end);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver
   // ---------------------------------------------------------------------------

   // The receiver owns its hold-off counter; a test only posts a request for a
   // hold-off, which is taken up at the next edge.
   always @(posedge clock) begin
      if (hold_off_request > 0) begin
         hold_off_left    = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_off_left  = hold_off_left - 1;
      end else if (idling_on) begin
         rsp_chan.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------------

   // Offers one request and returns once it has been taken. Valid is left high
   // on return, so back-to-back requests drop it between them only when idling.
   task automatic send_byte(input logic [7:0] rx, input logic fin);
      while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.rx_byte   <= rx;
      req_chan.frame_end <= fin;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // Adds one byte to the end of the frame being assembled.
   task automatic append_byte(input logic [7:0] value);
      frame_bytes.insert(frame_bytes.size(), value);
   endtask

   // Lays out a well-formed frame with a random counter byte and random payload;
   // the declared length and the real payload size are given separately.
   task automatic build_frame(input logic [7:0] ftype, input logic [15:0] declared,
                              input int body_len);
      frame_bytes.delete();
      append_byte(SYNC_HEAD);
      append_byte(SYNC_HEAD);
      append_byte(8'($urandom_range(255)));
      append_byte(ftype);
      append_byte(declared[7:0]);
      append_byte(declared[15:8]);
      repeat (body_len) append_byte(8'($urandom_range(255)));
      append_byte(SYNC_TAIL);
      append_byte(SYNC_TAIL);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // A handful of hand-made frames around the edges of the format.
   task automatic test_directed();
      // A good frame with a one-byte payload, extreme type and payload values.
      build_frame(8'hFF, 16'd1, 1);
      frame_bytes[6] = 8'h00;
      send_frame();

      // A frame of a single byte is too short and reports nothing held.
      frame_bytes.delete();
      append_byte(8'hFF);
      send_frame();

      // The largest declared length with no real payload: the tail bytes are
      // passed on as payload, and the marked one is replaced by the status.
      build_frame(8'h00, 16'hFFFF, 0);
      send_frame();

      // Cut off after the low length byte: type and low byte held, length zero.
      build_frame(8'h3C, 16'h0203, 0);
      while (frame_bytes.size() > 5) void'(frame_bytes.pop_back());
      send_frame();
   endtask

   // A stretch with neither side idling, so requests and results run at full rate.
   task automatic test_full_rate();
      int body;

      idling_on = 1'b0;
      repeat (15) begin
         body = $urandom_range(10);
         build_frame(8'($urandom_range(255)), 16'(body), body);
         send_frame();
      end
      idling_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while a long frame is offered,
   // so the result register fills and the block refuses further requests.
   task automatic test_receiver_hold_off();
      hold_off_request = HOLD_OFF_LONG;
      build_frame(8'($urandom_range(255)), 16'd40, 40);
      send_frame();
   endtask

   // Mostly well-formed frames with random content, the rest broken or noise.
   task automatic test_random_frames();
      int          pick;
      int          body;
      int          keep;
      int          idx;
      logic [7:0]  value;

      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         body = ($urandom_range(9) == 0) ? $urandom_range(48, 16) : $urandom_range(10);
         build_frame(8'($urandom_range(255)), 16'(body), body);
         if (pick < 60) begin
            // Left well-formed.
         end else if (pick < 70) begin
            frame_bytes[4] = 8'($urandom_range(255));
            frame_bytes[5] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
         end else if (pick < 77) begin
            value = 8'($urandom_range(255));
            if (value == SYNC_HEAD) value = 8'h00;
            frame_bytes[$urandom_range(1)] = value;
         end else if (pick < 84) begin
            idx = frame_bytes.size() - 1 - $urandom_range(1);
            frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(255, 1));
         end else if (pick < 91) begin
            // Truncated, so the mark may fall in the header or the payload.
            keep = $urandom_range(frame_bytes.size() - 1, 1);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
         end else if (pick < 96) begin
            // Extra bytes after the declared payload, which must not be emitted.
            repeat ($urandom_range(4, 1))
               frame_bytes.insert(frame_bytes.size() - 2, 8'($urandom_range(255)));
         end else begin
            frame_bytes.delete();
            repeat ($urandom_range(20, 1)) append_byte(8'($urandom_range(255)));
         end
         send_frame();
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------

   initial begin
      clear_frame_state();
      req_chan.valid     = 1'b0;
      req_chan.rx_byte   = '0;
      req_chan.frame_end = 1'b0;
      rsp_chan.ready     = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_rate();
      test_receiver_hold_off();
      test_random_frames();

      req_chan.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/slfc_pkg.sv
rtl/core/slfc_if.sv
rtl/core/slfc_parser.sv
rtl/core/slfc_out_reg.sv
rtl/core/sync_length_frame_checker.sv
bench/testbench.sv
